// ===== rtl/bfrlt_pkg.sv =====
// Shared constants, types and the command decoder of the run-length tokenizer.
package bfrlt_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_INDEX_BITS  = 16;
  localparam int DEF_COUNT_BITS  = 16;

  localparam int KIND_W = 4;
  localparam int ERR_W  = 2;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [ERR_W-1:0]  err_t;

  localparam kind_t KIND_NONE  = 4'd0;
  localparam kind_t KIND_LT    = 4'd1;
  localparam kind_t KIND_GT    = 4'd2;
  localparam kind_t KIND_PLUS  = 4'd3;
  localparam kind_t KIND_MINUS = 4'd4;
  localparam kind_t KIND_DOT   = 4'd5;
  localparam kind_t KIND_COMMA = 4'd6;
  localparam kind_t KIND_OPEN  = 4'd7;
  localparam kind_t KIND_CLOSE = 4'd8;

  localparam err_t ERR_OK         = 2'd0;
  localparam err_t ERR_UNMATCHED  = 2'd1;
  localparam err_t ERR_STILL_OPEN = 2'd2;
  localparam err_t ERR_TOO_DEEP   = 2'd3;

  localparam logic [7:0] CHR_LT    = 8'h3C;
  localparam logic [7:0] CHR_GT    = 8'h3E;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_OPEN  = 8'h5B;
  localparam logic [7:0] CHR_CLOSE = 8'h5D;

  // Result queue between the token logic and the output port.
  localparam int OUTQ_DEPTH = 4;

  // Stack control from the token logic to the bracket stack.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctl_t;

  // Bits of the packed result fields, rounded up to whole bytes.
  function automatic int out_data_width(int count_bits, int index_bits);
    int raw;
    raw = KIND_W + count_bits + 2 * index_bits + ERR_W;
    return ((raw + 7) / 8) * 8;
  endfunction

  function automatic kind_t classify(logic [7:0] b);
    kind_t k;
    unique case (b)
      CHR_LT:    k = KIND_LT;
      CHR_GT:    k = KIND_GT;
      CHR_PLUS:  k = KIND_PLUS;
      CHR_MINUS: k = KIND_MINUS;
      CHR_DOT:   k = KIND_DOT;
      CHR_COMMA: k = KIND_COMMA;
      CHR_OPEN:  k = KIND_OPEN;
      CHR_CLOSE: k = KIND_CLOSE;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/bf_run_length_tokenizer.sv =====
// Top level of the run-length tokenizer: input register, token logic, stack, result queue.
// A byte taken in a transfer is held in the input register, and its results are written
// to the result queue and leave from there. Throughput: one byte per cycle while the queue
// has room for two results; the four-entry queue absorbs a byte that causes two results.
// Reset: rst is synchronous and active high; it empties the input register and the queue
// and returns the token state and the bracket stack level to zero (stack entries keep data).
module bf_run_length_tokenizer #(
  parameter int STACK_DEPTH = bfrlt_pkg::DEF_STACK_DEPTH,
  parameter int INDEX_BITS  = bfrlt_pkg::DEF_INDEX_BITS,
  parameter int COUNT_BITS  = bfrlt_pkg::DEF_COUNT_BITS
) (
  input  logic clk,
  input  logic rst,
  // Input stream: tdata holds source_byte; tlast is end_of_text.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] source_byte
  input  logic       s_tlast,
  // Result stream: tlast is last_result.
  output logic m_tvalid,
  input  logic m_tready,
  // From bit 0 up: token_kind, repeat_count, token_index, partner_index, error_code,
  // zero padding to whole bytes.
  output logic [bfrlt_pkg::out_data_width(COUNT_BITS, INDEX_BITS)-1:0] m_tdata,
  output logic m_tlast
);
  import bfrlt_pkg::*;

  localparam int TDATA_W = out_data_width(COUNT_BITS, INDEX_BITS);
  localparam int RES_W   = TDATA_W + 1;
  localparam int LW      = $clog2(STACK_DEPTH + 1);

  // The input register holds one byte until the token logic can take it, that is
  // while the result queue has room for the two results a byte may cause.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       take;
  logic       q_room;

  stk_ctl_t              stk_ctl;
  logic [INDEX_BITS-1:0] stk_data;
  logic [LW-1:0]         stk_level;
  logic [INDEX_BITS-1:0] stk_top;

  logic [1:0]       push_n;
  logic [RES_W-1:0] res0;
  logic [RES_W-1:0] res1;
  logic [RES_W-1:0] q_data;

  assign take     = in_valid && q_room;
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  bfrlt_core #(
    .STACK_DEPTH (STACK_DEPTH),
    .INDEX_BITS  (INDEX_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .LW          (LW),
    .RES_W       (RES_W)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .src_byte  (in_byte),
    .src_last  (in_last),
    .stk_level (stk_level),
    .stk_top   (stk_top),
    .stk_ctl   (stk_ctl),
    .stk_data  (stk_data),
    .push_n    (push_n),
    .res0      (res0),
    .res1      (res1)
  );

  bfrlt_stack #(
    .DEPTH (STACK_DEPTH),
    .DW    (INDEX_BITS),
    .LW    (LW)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .ctl       (stk_ctl),
    .push_data (stk_data),
    .level     (stk_level),
    .top       (stk_top)
  );

  // Results leave from registers, so a stalled output does not stop the input
  // side until the queue runs short of room.
  bfrlt_outq #(
    .W (RES_W)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_d0   (res0),
    .push_d1   (res1),
    .room      (q_room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (q_data)
  );

  assign m_tdata = q_data[TDATA_W-1:0];
  assign m_tlast = q_data[RES_W-1];

endmodule

// ===== rtl/bfrlt_stack.sv =====
// Bracket stack: memory of open-bracket indexes with the top two entries in registers.
module bfrlt_stack #(
  parameter int DEPTH = 64,
  parameter int DW    = 16,
  parameter int LW    = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  bfrlt_pkg::stk_ctl_t ctl,
  input  logic [DW-1:0]      push_data,
  output logic [LW-1:0]      level,
  output logic [DW-1:0]      top
);
  import bfrlt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] second;
  logic [LW-1:0] rd_level;

  // Entry below the second one, which becomes the new second after a pop.
  assign rd_level = level - LW'(3);

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (ctl.clear) begin
      level <= '0;
    end else if (ctl.push) begin
      level <= level + LW'(1);
    end else if (ctl.pop) begin
      level <= level - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[level[AW-1:0]] <= push_data;
      top                <= push_data;
      second             <= top;
    end else if (ctl.pop) begin
      top <= second;
      if (level >= LW'(3)) begin
        second <= mem[rd_level[AW-1:0]];
      end
    end
  end

endmodule

// ===== rtl/bfrlt_outq.sv =====
// Small result queue that takes up to two results per cycle and gives out one.
module bfrlt_outq #(
  parameter int W = 57
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   push_n,
  input  logic [W-1:0] push_d0,
  input  logic [W-1:0] push_d1,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  import bfrlt_pkg::*;

  localparam int PW = $clog2(OUTQ_DEPTH);
  localparam int CW = $clog2(OUTQ_DEPTH + 1);

  logic [W-1:0]  q [OUTQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [PW-1:0] wr_ptr_inc;
  logic          pop;

  assign wr_ptr_inc = wr_ptr + PW'(1);
  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != '0);
  assign out_data   = q[rd_ptr];
  // Room for two results, the most that one byte can cause.
  assign room       = (count <= CW'(OUTQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push_n) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q[wr_ptr] <= push_d0;
    end
    if (push_n == 2'd2) begin
      q[wr_ptr_inc] <= push_d1;
    end
  end

endmodule

// ===== rtl/bfrlt_core.sv =====
// Token logic: run merging, indexing, bracket matching and error handling per byte.
module bfrlt_core #(
  parameter int STACK_DEPTH = 64,
  parameter int INDEX_BITS  = 16,
  parameter int COUNT_BITS  = 16,
  parameter int LW          = 7,
  parameter int RES_W       = 57
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            src_byte,
  input  logic                  src_last,
  input  logic [LW-1:0]         stk_level,
  input  logic [INDEX_BITS-1:0] stk_top,
  output bfrlt_pkg::stk_ctl_t   stk_ctl,
  output logic [INDEX_BITS-1:0] stk_data,
  output logic [1:0]            push_n,
  output logic [RES_W-1:0]      res0,
  output logic [RES_W-1:0]      res1
);
  import bfrlt_pkg::*;

  localparam int OFF_CNT  = KIND_W;
  localparam int OFF_IDX  = OFF_CNT + COUNT_BITS;
  localparam int OFF_PART = OFF_IDX + INDEX_BITS;
  localparam int OFF_ERR  = OFF_PART + INDEX_BITS;
  localparam int OFF_LAST = RES_W - 1;

  kind_t                 open_kind,    open_kind_next;
  logic [COUNT_BITS-1:0] open_count,   open_count_next;
  logic [INDEX_BITS-1:0] open_partner, open_partner_next;
  logic [INDEX_BITS-1:0] next_index,   next_index_next;
  err_t                  sticky_error, sticky_error_next;

  kind_t                 cls;
  logic                  flush_req;
  logic                  emit_flush;
  logic                  open_new;
  kind_t                 new_kind;
  logic [INDEX_BITS-1:0] new_partner;
  logic                  fail;
  err_t                  fail_err;
  logic                  has_second;
  logic [RES_W-1:0]      flush_res;
  logic [RES_W-1:0]      second_res;
  logic [INDEX_BITS-1:0] idx1;
  logic                  open_after;
  err_t                  end_err;
  logic                  clear;

  function automatic logic [RES_W-1:0] pack_res(kind_t k, logic [COUNT_BITS-1:0] c,
                                                logic [INDEX_BITS-1:0] i,
                                                logic [INDEX_BITS-1:0] p, err_t e,
                                                logic l);
    logic [RES_W-1:0] r;
    r                       = '0;
    r[KIND_W-1:0]           = k;
    r[OFF_CNT +: COUNT_BITS] = c;
    r[OFF_IDX +: INDEX_BITS] = i;
    r[OFF_PART +: INDEX_BITS] = p;
    r[OFF_ERR +: ERR_W]     = e;
    r[OFF_LAST]             = l;
    return r;
  endfunction

  assign cls = classify(src_byte);

  always_comb begin
    flush_req   = 1'b0;
    open_new    = 1'b0;
    new_kind    = cls;
    new_partner = '0;
    fail        = 1'b0;
    fail_err    = ERR_OK;
    stk_ctl     = '0;

    if (take && sticky_error == ERR_OK) begin
      case (cls) inside
        KIND_LT, KIND_GT, KIND_PLUS, KIND_MINUS, KIND_DOT: begin
          if (open_kind != cls || open_count == '1) begin
            flush_req = 1'b1;
            open_new  = 1'b1;
          end
        end
        KIND_COMMA: begin
          flush_req = 1'b1;
          open_new  = 1'b1;
        end
        KIND_OPEN: begin
          flush_req = 1'b1;
          if (stk_level >= LW'(STACK_DEPTH)) begin
            fail     = 1'b1;
            fail_err = ERR_TOO_DEEP;
          end else begin
            open_new     = 1'b1;
            stk_ctl.push = 1'b1;
          end
        end
        KIND_CLOSE: begin
          flush_req = 1'b1;
          if (stk_level == '0) begin
            fail     = 1'b1;
            fail_err = ERR_UNMATCHED;
          end else begin
            open_new    = 1'b1;
            new_partner = stk_top;
            stk_ctl.pop = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    emit_flush = flush_req && (open_kind != KIND_NONE);
    idx1       = emit_flush ? next_index + INDEX_BITS'(1) : next_index;
    flush_res  = pack_res(open_kind, open_count, next_index, open_partner, ERR_OK, 1'b0);

    // The new '[' gets the index after the flushed token.
    stk_data = idx1;

    open_kind_next    = open_kind;
    open_count_next   = open_count;
    open_partner_next = open_partner;
    if (open_new) begin
      open_kind_next    = new_kind;
      open_count_next   = COUNT_BITS'(1);
      open_partner_next = new_partner;
    end else if (emit_flush) begin
      open_kind_next    = KIND_NONE;
      open_count_next   = '0;
      open_partner_next = '0;
    end else if (take && sticky_error == ERR_OK && cls != KIND_NONE) begin
      open_count_next = open_count + COUNT_BITS'(1);
    end
    next_index_next   = idx1;
    sticky_error_next = sticky_error;

    // Brackets still open once this byte's push or pop has taken effect.
    open_after = stk_ctl.push ||
                 (stk_level != '0 && !(stk_ctl.pop && stk_level == LW'(1)));
    end_err    = open_after ? ERR_STILL_OPEN : ERR_OK;

    has_second = 1'b0;
    second_res = pack_res(KIND_NONE, '0, idx1, '0, fail_err, 1'b1);
    clear      = 1'b0;
    if (take) begin
      if (sticky_error != ERR_OK) begin
        clear = src_last;
      end else if (fail) begin
        has_second        = 1'b1;
        sticky_error_next = fail_err;
        clear             = src_last;
      end else if (src_last) begin
        has_second = 1'b1;
        clear      = 1'b1;
        if (open_kind_next != KIND_NONE) begin
          second_res = pack_res(open_kind_next, open_count_next, idx1, open_partner_next,
                                end_err, 1'b1);
        end else begin
          second_res = pack_res(KIND_NONE, '0, idx1, '0, end_err, 1'b1);
        end
      end
    end
    stk_ctl.clear = clear;

    if (emit_flush) begin
      res0   = flush_res;
      res1   = second_res;
      push_n = has_second ? 2'd2 : 2'd1;
    end else begin
      res0   = second_res;
      res1   = second_res;
      push_n = has_second ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      open_kind    <= KIND_NONE;
      open_count   <= '0;
      open_partner <= '0;
      next_index   <= '0;
      sticky_error <= ERR_OK;
    end else begin
      open_kind    <= open_kind_next;
      open_count   <= open_count_next;
      open_partner <= open_partner_next;
      next_index   <= next_index_next;
      sticky_error <= sticky_error_next;
    end
  end

endmodule

// ===== rtl/bfrlt_checker.sv =====
// Port-level checks of the run-length tokenizer and their attachment to the top level.
module bfrlt_checker #(
  parameter int INDEX_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic [7:0] s_tdata,
  input logic s_tlast,
  input logic m_tvalid,
  input logic m_tready,
  input logic [bfrlt_pkg::out_data_width(COUNT_BITS, INDEX_BITS)-1:0] m_tdata,
  input logic m_tlast
);
  import bfrlt_pkg::*;

  localparam int OFF_CNT = KIND_W;
  localparam int OFF_ERR = KIND_W + COUNT_BITS + 2 * INDEX_BITS;

  logic [KIND_W-1:0]     kind;
  logic [COUNT_BITS-1:0] cnt;
  logic [ERR_W-1:0]      err;
  logic                  in_seen;

  assign kind    = m_tdata[KIND_W-1:0];
  assign cnt     = m_tdata[OFF_CNT +: COUNT_BITS];
  assign err     = m_tdata[OFF_ERR +: ERR_W];
  assign in_seen = s_tvalid && s_tready && (s_tdata != 8'd0 || s_tlast);

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // End markers carry no count and always close the stream.
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && kind == KIND_NONE) |-> (m_tlast && cnt == '0))
    else $error("end marker with count or without last");

  // Real tokens hold at least one repetition.
  a_token_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && kind != KIND_NONE) |-> (cnt != '0))
    else $error("token with zero repeat count");

  // An error code only travels on the final result of a stream.
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && err != ERR_OK) |-> m_tlast)
    else $error("error code on a result that is not last");

  // A stalled result is held unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst || in_seen && 1'b0)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind bf_run_length_tokenizer bfrlt_checker #(
  .INDEX_BITS (INDEX_BITS),
  .COUNT_BITS (COUNT_BITS)
) u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== dv/bf_run_length_tokenizer_tb.sv =====
// Self-checking testbench for the run-length tokenizer, with its own token predictor.
module bf_run_length_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfrlt_pkg::*;

  // The block is built with its default sizes, and the predictor uses the same ones.
  localparam int STACK_DEPTH = DEF_STACK_DEPTH;
  localparam int IDX_W       = DEF_INDEX_BITS;
  localparam int CNT_W       = DEF_COUNT_BITS;
  localparam int DATA_W      = out_data_width(CNT_W, IDX_W);

  // Bit positions of the result fields in m_tdata, from bit 0 up.
  localparam int CNT_LO = KIND_W;
  localparam int IDX_LO = CNT_LO + CNT_W;
  localparam int PAR_LO = IDX_LO + IDX_W;
  localparam int ERR_LO = PAR_LO + IDX_W;
  localparam int PAD_LO = ERR_LO + ERR_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // The run ends here if the traffic stalls.
  localparam int LIMIT_CYCLES = 1_000_000;
  // Cycles to watch for stray results once every expected token has arrived.
  localparam int DRAIN_CYCLES = 8;
  // Number of command bytes that the random part sends.
  localparam int RANDOM_COMMANDS = 500;
  localparam int MAX_GAP = 18;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    kind_t            kind;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] index;
    logic [IDX_W-1:0] partner;
    err_t             err;
    logic             last;
  } token_t;

  logic clk = 1'b0;
  logic rst;

  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;
  logic              s_tlast;
  logic              m_tvalid;
  logic              m_tready;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tlast;

  bf_run_length_tokenizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tokens that the predictor has produced and the block has not yet delivered, oldest first.
  token_t pending_tokens[$];

  // Program text of the test that is running; the last byte goes out with end of text.
  logic [7:0] prog_bytes[$];

  int mismatch_count = 0;
  int commands_sent  = 0;

  // Upper bounds of the idle cycles that the sender and the receiver draw per transfer.
  // Setting one to zero gives a stretch with no idling on that side.
  int send_gap_max = MAX_GAP;
  int take_gap_max = MAX_GAP;

  // ---------------------------------------------------------------------------------------
  // Token predictor. It mirrors the block's state: the open token that is still growing,
  // the index that the next token gets, the stack of open-bracket indexes and the sticky
  // error that silences the rest of a broken program.
  // ---------------------------------------------------------------------------------------
  kind_t            held_kind;
  logic [CNT_W-1:0] held_count;
  logic [IDX_W-1:0] held_partner;
  logic [IDX_W-1:0] token_number;
  logic [IDX_W-1:0] open_marks[STACK_DEPTH];
  int               nest_level;
  err_t             halted_err;

  function automatic kind_t command_of(logic [7:0] b);
    case (b)
      CHR_LT:    return KIND_LT;
      CHR_GT:    return KIND_GT;
      CHR_PLUS:  return KIND_PLUS;
      CHR_MINUS: return KIND_MINUS;
      CHR_DOT:   return KIND_DOT;
      CHR_COMMA: return KIND_COMMA;
      CHR_OPEN:  return KIND_OPEN;
      CHR_CLOSE: return KIND_CLOSE;
      default:   return KIND_NONE;
    endcase
  endfunction

  task automatic clear_tokenizer();
    held_kind    = KIND_NONE;
    held_count   = '0;
    held_partner = '0;
    token_number = '0;
    nest_level   = 0;
    halted_err   = ERR_OK;
  endtask

  task automatic expect_token(kind_t kind, logic [CNT_W-1:0] count, logic [IDX_W-1:0] index,
                              logic [IDX_W-1:0] partner, err_t err, logic last);
    pending_tokens.push_back('{kind, count, index, partner, err, last});
  endtask

  // Gives out the open token, if there is one, and moves on to the next index.
  task automatic release_held(logic last, err_t err);
    if (held_kind != KIND_NONE) begin
      expect_token(held_kind, held_count, token_number, held_partner, err, last);
      token_number = token_number + 1'b1;
      held_kind    = KIND_NONE;
      held_count   = '0;
      held_partner = '0;
    end
  endtask

  task automatic hold_new(kind_t kind, logic [IDX_W-1:0] partner);
    held_kind    = kind;
    held_count   = CNT_W'(1);
    held_partner = partner;
  endtask

  // A bracket error closes the program early: the open token goes out, then an end marker
  // with the error code, and the block ignores bytes until the end of the text.
  task automatic abort_program(err_t err, logic eot);
    release_held(1'b0, ERR_OK);
    expect_token(KIND_NONE, '0, token_number, '0, err, 1'b1);
    halted_err = err;
    if (eot) clear_tokenizer();
  endtask

  task automatic tokenize_byte(logic [7:0] b, logic eot);
    kind_t kind;
    err_t  end_err;
    if (halted_err != ERR_OK) begin
      if (eot) clear_tokenizer();
      return;
    end
    kind = command_of(b);
    case (kind) inside
      KIND_LT, KIND_GT, KIND_PLUS, KIND_MINUS, KIND_DOT: begin
        // Equal commands merge until the count saturates; then a fresh run begins.
        if (held_kind == kind && held_count != COUNT_MAX) begin
          held_count = held_count + 1'b1;
        end else begin
          release_held(1'b0, ERR_OK);
          hold_new(kind, '0);
        end
      end
      KIND_COMMA: begin
        release_held(1'b0, ERR_OK);
        hold_new(kind, '0);
      end
      KIND_OPEN: begin
        if (nest_level >= STACK_DEPTH) begin
          abort_program(ERR_TOO_DEEP, eot);
          return;
        end
        release_held(1'b0, ERR_OK);
        hold_new(kind, '0);
        open_marks[nest_level] = token_number;
        nest_level++;
      end
      KIND_CLOSE: begin
        if (nest_level == 0) begin
          abort_program(ERR_UNMATCHED, eot);
          return;
        end
        release_held(1'b0, ERR_OK);
        nest_level--;
        hold_new(kind, open_marks[nest_level]);
      end
      default: ;
    endcase
    if (eot) begin
      end_err = (nest_level != 0) ? ERR_STILL_OPEN : ERR_OK;
      if (held_kind != KIND_NONE) begin
        release_held(1'b1, end_err);
      end else begin
        expect_token(KIND_NONE, '0, token_number, '0, end_err, 1'b1);
      end
      clear_tokenizer();
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Sender. Every byte waits a random number of idle cycles, then stays valid until its
  // transfer. The predictor sees the byte at the rising edge that accepts it.
  // ---------------------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic eot);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = eot;
    do @(posedge clk); while (!s_tready);
    tokenize_byte(b, eot);
    if (command_of(b) != KIND_NONE) commands_sent++;
    @(negedge clk);
  endtask

  task automatic play_program();
    foreach (prog_bytes[i]) send_byte(prog_bytes[i], i == prog_bytes.size() - 1);
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver. Before each result it stalls for a random number of cycles, then holds
  // m_tready high until a transfer takes place.
  // ---------------------------------------------------------------------------------------
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, take_gap_max);
      if (stall != 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  function automatic string token_text(token_t t);
    return $sformatf("kind %0d count %0d index %0d partner %0d err %0d last %0b",
                     t.kind, t.count, t.index, t.partner, t.err, t.last);
  endfunction

  // Every result transfer is compared with the oldest token still expected. The padding
  // bits above the error code must be zero as well.
  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind    = m_tdata[KIND_W-1:0];
      got.count   = m_tdata[CNT_LO +: CNT_W];
      got.index   = m_tdata[IDX_LO +: IDX_W];
      got.partner = m_tdata[PAR_LO +: IDX_W];
      got.err     = m_tdata[ERR_LO +: ERR_W];
      got.last    = m_tlast;
      if (pending_tokens.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result with none expected: %s", $realtime, token_text(got));
      end else begin
        want = pending_tokens.pop_front();
        if (got !== want || m_tdata[DATA_W-1:PAD_LO] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch\n  expected %s\n  actual   %s (padding %0h)", $realtime,
                     token_text(want), token_text(got), m_tdata[DATA_W-1:PAD_LO]);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // Every command, merged and unmerged runs, and the lowest and highest non-command bytes,
  // which must be dropped without a token.
  task automatic test_all_commands();
    prog_bytes = '{8'h00, CHR_LT, CHR_LT, CHR_GT, CHR_PLUS, CHR_MINUS, CHR_DOT, CHR_COMMA,
                   CHR_COMMA, CHR_OPEN, CHR_CLOSE, 8'hFF};
    play_program();
  endtask

  // A program with no command gets only an end marker; a program that ends on an open
  // bracket gives that bracket as the last token, flagged as still open.
  task automatic test_text_end();
    prog_bytes = '{8'hA5};
    play_program();
    prog_bytes = '{CHR_DOT, CHR_OPEN};
    play_program();
  endtask

  // A close bracket with nothing open stops the program. The bytes after it give nothing
  // until the end of the text, and the next program starts from a clean state.
  task automatic test_unmatched_close();
    prog_bytes = '{CHR_PLUS, CHR_CLOSE, CHR_PLUS, CHR_OPEN, 8'h5A};
    play_program();
    prog_bytes = '{CHR_CLOSE};
    play_program();
  endtask

  // Fills the bracket stack to its full depth and empties it, then overflows it once in the
  // middle of a program and once on the final byte.
  task automatic test_deep_nesting();
    prog_bytes.delete();
    for (int i = 0; i < STACK_DEPTH; i++) begin
      prog_bytes.push_back(CHR_OPEN);
      prog_bytes.push_back(CHR_PLUS);
    end
    repeat (STACK_DEPTH) prog_bytes.push_back(CHR_CLOSE);
    prog_bytes.push_back(CHR_DOT);
    play_program();

    prog_bytes.delete();
    repeat (STACK_DEPTH + 1) prog_bytes.push_back(CHR_OPEN);
    prog_bytes.push_back(CHR_MINUS);
    prog_bytes.push_back(CHR_CLOSE);
    prog_bytes.push_back(8'h20);
    play_program();

    prog_bytes.delete();
    repeat (STACK_DEPTH + 1) prog_bytes.push_back(CHR_OPEN);
    play_program();
  endtask

  // Random programs. Most are well formed: runs of repeatable commands, input commands,
  // balanced brackets and stray text. About one in five may close brackets that are not
  // open or leave some open. Some programs run with no idling on one side or both.
  task automatic test_random_programs();
    int target;
    int len;
    int depth;
    int pick;
    int run;
    bit broken;
    logic [7:0] cmd;
    target = commands_sent + RANDOM_COMMANDS;
    while (commands_sent < target) begin
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      take_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      broken = ($urandom_range(0, 4) == 0);
      len    = $urandom_range(1, 30);
      depth  = 0;
      prog_bytes.delete();
      while (prog_bytes.size() < len) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          case ($urandom_range(0, 4))
            0:       cmd = CHR_LT;
            1:       cmd = CHR_GT;
            2:       cmd = CHR_PLUS;
            3:       cmd = CHR_MINUS;
            default: cmd = CHR_DOT;
          endcase
          run = $urandom_range(1, 6);
          repeat (run) prog_bytes.push_back(cmd);
        end else if (pick < 55) begin
          prog_bytes.push_back(CHR_COMMA);
        end else if (pick < 70) begin
          if (depth < 8 || broken) begin
            prog_bytes.push_back(CHR_OPEN);
            depth++;
          end
        end else if (pick < 85) begin
          if (depth > 0 || broken) begin
            prog_bytes.push_back(CHR_CLOSE);
            if (depth > 0) depth--;
          end
        end else begin
          prog_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      if (!broken) repeat (depth) prog_bytes.push_back(CHR_CLOSE);
      // Half of the programs end on one more random byte, which is mostly stray text.
      if ($urandom_range(0, 1) == 0) prog_bytes.push_back(8'($urandom_range(0, 255)));
      play_program();
    end
    send_gap_max = MAX_GAP;
    take_gap_max = MAX_GAP;
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    clear_tokenizer();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_all_commands();
    test_text_end();
    test_unmatched_close();
    test_deep_nesting();
    test_random_programs();

    s_tvalid = 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += pending_tokens.size();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
